// File: design/htok_pkg.sv
`timescale 1ns / 1ps

package htok_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_METHOD  = 3'd0,
    PH_URL     = 3'd1,
    PH_VERSION = 3'd2,
    PH_KEY     = 3'd3,
    PH_VALUE   = 3'd4,
    PH_BODY    = 3'd5,
    PH_FINISH  = 3'd6,
    PH_LINE    = 3'd7
  } phase_t;

  // Number reader phases
  typedef enum logic [1:0] {
    DG_LEAD   = 2'd0,
    DG_DIGITS = 2'd1,
    DG_DONE   = 2'd3
  } digit_t;

  // Field kind codes
  localparam logic [2:0] KIND_METHOD  = 3'd0;
  localparam logic [2:0] KIND_URL     = 3'd1;
  localparam logic [2:0] KIND_VERSION = 3'd2;
  localparam logic [2:0] KIND_KEY     = 3'd3;
  localparam logic [2:0] KIND_VALUE   = 3'd4;
  localparam logic [2:0] KIND_BODY    = 3'd5;

  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CRET  = 8'h0d;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Key match position: length of the matched "Content-Length" prefix,
  // or KEY_MISS once the key diverged.
  localparam logic [3:0] KEY_LEN  = 4'd14;
  localparam logic [3:0] KEY_MISS = 4'd15;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef struct packed {
    logic [2:0]  field_kind;
    logic [7:0]  data;
    logic        byte_valid;
    logic        field_done;
    logic        header_done;
    logic        request_done;
    logic [31:0] body_length;
    logic        last_result;
  } res_t;

  function automatic logic [7:0] key_char(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h43; // C
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h4c; // L
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic res_t mk_res(input logic [2:0] kind, input logic [7:0] b,
                                  input logic valid, input logic fdone,
                                  input logic hdone, input logic rdone);
    res_t r;
    r.field_kind   = kind;
    r.data         = valid ? b : 8'h00;
    r.byte_valid   = valid;
    r.field_done   = fdone;
    r.header_done  = hdone;
    r.request_done = rdone;
    r.body_length  = 32'd0;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

// File: design/htok_fifo.sv
`timescale 1ns / 1ps

module htok_fifo (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [1:0]                  push_cnt,
  input  htok_pkg::res_t              push0,
  input  htok_pkg::res_t              push1,
  input  logic                        pop,
  output htok_pkg::res_t              head,
  output logic                        head_valid,
  output logic [htok_pkg::FIFO_AW:0]  fill
);

  htok_pkg::res_t mem [htok_pkg::FIFO_DEPTH];

  logic [htok_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [htok_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [htok_pkg::FIFO_AW:0]   fill_r, fill_nxt;
  logic [htok_pkg::FIFO_AW-1:0] wr_ptr_p1;

  assign wr_ptr_p1 = htok_pkg::FIFO_AW'(wr_ptr_r + 1'b1);

  always_comb begin
    wr_ptr_nxt = htok_pkg::FIFO_AW'(wr_ptr_r + push_cnt);
    rd_ptr_nxt = pop ? htok_pkg::FIFO_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    fill_nxt   = (htok_pkg::FIFO_AW+1)'(fill_r + push_cnt - {2'b00, pop});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_ptr_p1] <= push1;
    end
  end

  assign head       = mem[rd_ptr_r];
  assign head_valid = (fill_r != '0);
  assign fill       = fill_r;

endmodule

// File: design/http_request_tokenizer_core.sv
`timescale 1ns / 1ps

// HTTP/1.1 request tokenizer.
// Input channel (in_valid / in_stall): one request byte per transfer, with
// in_buffer_end marking the last byte of a received buffer.
// Result channel (out_valid / out_stall): tagged bytes and delimiter events
// (method, URL, version, header key, header value, body), plus header and
// request completion flags and the Content-Length in use. One byte gives
// zero, one or two results; out_last_result marks the last one of a byte.
// Results of a byte are written into the result queue at its transfer.
// Throughput: one byte per cycle while out_stall is low and each byte gives
// at most one result; a byte with two results needs two output transfers.
// The parser state updates at the input transfer; results go into a four-entry
// result queue, and in_stall rises once fewer than two free slots remain, so a
// stalled receiver backs up the input after two or three result-giving bytes.
// Reset (synchronous, rst_n low) returns the parser to the method phase,
// clears the length, counters and the queue.
// After the request completes, further bytes are taken and give no result.
module http_request_tokenizer_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_buffer_end,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_field_kind,
  output logic [7:0]  out_byte,
  output logic        out_byte_valid,
  output logic        out_field_done,
  output logic        out_header_done,
  output logic        out_request_done,
  output logic [31:0] out_body_length,
  output logic        out_last_result
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam int unsigned            WIDE    = LENGTH_BITS + 4;

  // Parser state
  htok_pkg::phase_t       phase_r, phase_nxt;
  logic                   pend_r, pend_nxt;     // CR held for the next byte
  logic [3:0]             kmp_r, kmp_nxt;       // key match position
  logic                   klen_r, klen_nxt;     // current key is Content-Length
  htok_pkg::digit_t       dp_r, dp_nxt;
  logic [LENGTH_BITS-1:0] acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] cl_r, cl_nxt;
  logic [LENGTH_BITS-1:0] rc_r, rc_nxt;
  logic                   skip_r, skip_nxt;

  // Per-byte working signals
  logic                   in_xfer;
  logic                   out_xfer;
  logic [1:0]             n_res;
  htok_pkg::res_t         r0, r1, kres;
  logic                   do_key, key_slot1;
  logic [3:0]             kmp_in;
  logic                   do_num;
  htok_pkg::digit_t       dp_in;
  logic                   is_digit;
  logic [LENGTH_BITS-1:0] dval;
  logic [WIDE-1:0]        acc_wide;
  logic [WIDE-1:0]        prod;
  logic [LENGTH_BITS-1:0] rc_inc;
  logic [LENGTH_BITS+31:0] cl_ext;

  htok_pkg::res_t         head;
  logic                   head_valid;
  logic [htok_pkg::FIFO_AW:0] fill;

  assign in_stall = (fill > (htok_pkg::FIFO_AW+1)'(htok_pkg::FIFO_DEPTH - 2));
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = head_valid && !out_stall;

  // Digit value and saturating acc*10+d, done with shifts and two adds
  assign is_digit = (in_byte >= htok_pkg::CH_ZERO) && (in_byte <= htok_pkg::CH_NINE);
  assign dval     = is_digit ? LENGTH_BITS'(in_byte - htok_pkg::CH_ZERO) : '0;
  assign acc_wide = WIDE'(acc_r);
  assign prod     = (acc_wide << 3) + (acc_wide << 1) + WIDE'(dval);
  assign rc_inc   = LENGTH_BITS'(rc_r + 1'b1);

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    kmp_nxt   = kmp_r;
    klen_nxt  = klen_r;
    dp_nxt    = dp_r;
    acc_nxt   = acc_r;
    cl_nxt    = cl_r;
    rc_nxt    = rc_r;
    skip_nxt  = skip_r;
    n_res     = 2'd0;
    r0        = '0;
    r1        = '0;
    kres      = '0;
    do_key    = 1'b0;
    key_slot1 = 1'b0;
    kmp_in    = kmp_r;
    do_num    = 1'b0;
    dp_in     = dp_r;

    if (in_xfer) begin
      case (phase_r)
        htok_pkg::PH_METHOD: begin
          n_res = 2'd1;
          if (in_byte == htok_pkg::CH_SP) begin
            r0 = htok_pkg::mk_res(htok_pkg::KIND_METHOD, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            phase_nxt = htok_pkg::PH_URL;
          end else begin
            r0 = htok_pkg::mk_res(htok_pkg::KIND_METHOD, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
          end
        end
        htok_pkg::PH_URL: begin
          n_res = 2'd1;
          if (in_byte == htok_pkg::CH_SP) begin
            r0 = htok_pkg::mk_res(htok_pkg::KIND_URL, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            phase_nxt = htok_pkg::PH_VERSION;
            pend_nxt  = 1'b0;
          end else begin
            r0 = htok_pkg::mk_res(htok_pkg::KIND_URL, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
          end
        end
        htok_pkg::PH_VERSION: begin
          if (pend_r && in_byte == htok_pkg::CH_LF) begin
            r0 = htok_pkg::mk_res(htok_pkg::KIND_VERSION, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            n_res     = 2'd1;
            phase_nxt = htok_pkg::PH_LINE;
            pend_nxt  = 1'b0;
          end else if (pend_r) begin
            // Lone CR: release it as content, then treat this byte afresh
            r0 = htok_pkg::mk_res(htok_pkg::KIND_VERSION, htok_pkg::CH_CR, 1'b1,
                                  1'b0, 1'b0, 1'b0);
            if (in_byte == htok_pkg::CH_CR) begin
              n_res    = 2'd1;
              pend_nxt = 1'b1;
            end else begin
              r1 = htok_pkg::mk_res(htok_pkg::KIND_VERSION, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
              n_res    = 2'd2;
              pend_nxt = 1'b0;
            end
          end else if (in_byte == htok_pkg::CH_CR) begin
            pend_nxt = 1'b1;
          end else begin
            r0 = htok_pkg::mk_res(htok_pkg::KIND_VERSION, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
            n_res = 2'd1;
          end
        end
        htok_pkg::PH_KEY: begin
          do_key = 1'b1;
        end
        htok_pkg::PH_VALUE: begin
          if (pend_r && in_byte == htok_pkg::CH_LF) begin
            if (klen_r) begin
              cl_nxt = acc_r;
            end
            r0 = htok_pkg::mk_res(htok_pkg::KIND_VALUE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
            n_res     = 2'd1;
            phase_nxt = htok_pkg::PH_LINE;
            pend_nxt  = 1'b0;
          end else if (pend_r) begin
            // Lone CR is content; it also ends a number in progress
            r0 = htok_pkg::mk_res(htok_pkg::KIND_VALUE, htok_pkg::CH_CR, 1'b1,
                                  1'b0, 1'b0, 1'b0);
            dp_in  = (dp_r == htok_pkg::DG_DIGITS) ? htok_pkg::DG_DONE : dp_r;
            dp_nxt = dp_in;
            if (in_byte == htok_pkg::CH_CR) begin
              n_res    = 2'd1;
              pend_nxt = 1'b1;
            end else begin
              r1 = htok_pkg::mk_res(htok_pkg::KIND_VALUE, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
              n_res    = 2'd2;
              pend_nxt = 1'b0;
              do_num   = 1'b1;
            end
          end else if (in_byte == htok_pkg::CH_CR) begin
            pend_nxt = 1'b1;
          end else begin
            r0 = htok_pkg::mk_res(htok_pkg::KIND_VALUE, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
            n_res  = 2'd1;
            do_num = 1'b1;
          end
        end
        htok_pkg::PH_LINE: begin
          if (!pend_r) begin
            if (in_byte == htok_pkg::CH_CR) begin
              pend_nxt = 1'b1;
            end else begin
              phase_nxt = htok_pkg::PH_KEY;
              pend_nxt  = 1'b0;
              kmp_in    = 4'd0;
              do_key    = 1'b1;
            end
          end else begin
            pend_nxt = 1'b0;
            if (in_byte == htok_pkg::CH_LF) begin
              // Blank line: headers end here
              n_res = 2'd1;
              if (cl_r == '0) begin
                phase_nxt = htok_pkg::PH_FINISH;
                r0 = htok_pkg::mk_res(htok_pkg::KIND_BODY, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
              end else begin
                phase_nxt = htok_pkg::PH_BODY;
                r0 = htok_pkg::mk_res(htok_pkg::KIND_BODY, 8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
              end
            end else begin
              // CR at line start without LF: new key opens with the CR
              phase_nxt = htok_pkg::PH_KEY;
              r0 = htok_pkg::mk_res(htok_pkg::KIND_KEY, htok_pkg::CH_CR, 1'b1,
                                    1'b0, 1'b0, 1'b0);
              kmp_in    = htok_pkg::KEY_MISS;
              do_key    = 1'b1;
              key_slot1 = 1'b1;
            end
          end
        end
        htok_pkg::PH_BODY: begin
          if (skip_r) begin
            if (in_buffer_end) begin
              skip_nxt = 1'b0;
            end
          end else if (in_byte == htok_pkg::CH_NUL) begin
            if (!in_buffer_end) begin
              skip_nxt = 1'b1;
            end
          end else begin
            rc_nxt = rc_inc;
            n_res  = 2'd1;
            if (rc_inc >= cl_r) begin
              phase_nxt = htok_pkg::PH_FINISH;
              r0 = htok_pkg::mk_res(htok_pkg::KIND_BODY, in_byte, 1'b1, 1'b1, 1'b0, 1'b1);
            end else begin
              r0 = htok_pkg::mk_res(htok_pkg::KIND_BODY, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
            end
          end
        end
        default: begin
          // finished: drop the byte
        end
      endcase

      // Header key byte: colon closes the key, anything else advances the match
      if (do_key) begin
        if (in_byte == htok_pkg::CH_COLON) begin
          klen_nxt  = (kmp_in == htok_pkg::KEY_LEN);
          dp_nxt    = htok_pkg::DG_LEAD;
          acc_nxt   = '0;
          phase_nxt = htok_pkg::PH_VALUE;
          pend_nxt  = 1'b0;
          kmp_nxt   = kmp_in;
          kres = htok_pkg::mk_res(htok_pkg::KIND_KEY, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
        end else begin
          if (kmp_in < htok_pkg::KEY_LEN && in_byte == htok_pkg::key_char(kmp_in)) begin
            kmp_nxt = 4'(kmp_in + 4'd1);
          end else begin
            kmp_nxt = htok_pkg::KEY_MISS;
          end
          kres = htok_pkg::mk_res(htok_pkg::KIND_KEY, in_byte, 1'b1, 1'b0, 1'b0, 1'b0);
        end
        if (key_slot1) begin
          r1    = kres;
          n_res = 2'd2;
        end else begin
          r0    = kres;
          n_res = 2'd1;
        end
      end

      // Content-Length reader: skip leading blanks, optional sign, digits
      if (do_num) begin
        dp_nxt = dp_in;
        case (dp_in)
          htok_pkg::DG_LEAD: begin
            if (in_byte inside {htok_pkg::CH_SP, [htok_pkg::CH_TAB:htok_pkg::CH_CRET]}) begin
              dp_nxt = htok_pkg::DG_LEAD;
            end else if (in_byte == htok_pkg::CH_PLUS) begin
              dp_nxt = htok_pkg::DG_DIGITS;
            end else if (in_byte == htok_pkg::CH_MINUS) begin
              acc_nxt = '0;
              dp_nxt  = htok_pkg::DG_DONE;
            end else if (is_digit) begin
              acc_nxt = dval;
              dp_nxt  = htok_pkg::DG_DIGITS;
            end else begin
              dp_nxt = htok_pkg::DG_DONE;
            end
          end
          htok_pkg::DG_DIGITS: begin
            if (!is_digit) begin
              dp_nxt = htok_pkg::DG_DONE;
            end else if (prod > WIDE'(LEN_MAX)) begin
              acc_nxt = LEN_MAX;
            end else begin
              acc_nxt = prod[LENGTH_BITS-1:0];
            end
          end
          default: begin
            dp_nxt = dp_in;
          end
        endcase
      end
    end

    // Every result carries the length in force after this byte
    cl_ext         = {32'd0, cl_nxt};
    r0.body_length = cl_ext[31:0];
    r1.body_length = cl_ext[31:0];
    r0.last_result = (n_res == 2'd1);
    r1.last_result = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= htok_pkg::PH_METHOD;
      pend_r  <= 1'b0;
      kmp_r   <= 4'd0;
      klen_r  <= 1'b0;
      dp_r    <= htok_pkg::DG_LEAD;
      acc_r   <= '0;
      cl_r    <= '0;
      rc_r    <= '0;
      skip_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      kmp_r   <= kmp_nxt;
      klen_r  <= klen_nxt;
      dp_r    <= dp_nxt;
      acc_r   <= acc_nxt;
      cl_r    <= cl_nxt;
      rc_r    <= rc_nxt;
      skip_r  <= skip_nxt;
    end
  end

  // Result queue: up to two writes per input transfer, one read per output transfer
  htok_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (n_res),
    .push0      (r0),
    .push1      (r1),
    .pop        (out_xfer),
    .head       (head),
    .head_valid (head_valid),
    .fill       (fill)
  );

  assign out_valid        = head_valid;
  assign out_field_kind   = head.field_kind;
  assign out_byte         = head.data;
  assign out_byte_valid   = head.byte_valid;
  assign out_field_done   = head.field_done;
  assign out_header_done  = head.header_done;
  assign out_request_done = head.request_done;
  assign out_body_length  = head.body_length;
  assign out_last_result  = head.last_result;

  // Queue never holds more than its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    fill <= (htok_pkg::FIFO_AW+1)'(htok_pkg::FIFO_DEPTH))
    else $error("result queue overflow");

  // A result that is not the last of its byte has its partner queued behind it
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_result) |-> (fill >= (htok_pkg::FIFO_AW+1)'(2)))
    else $error("first of two results shown without its partner");

  // Request completion always closes the current field
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_request_done) |-> out_field_done)
    else $error("request done without field done");

  // Once finished, the parser never leaves the finished phase
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == htok_pkg::PH_FINISH) |=> (phase_r == htok_pkg::PH_FINISH))
    else $error("parser left finished phase");

endmodule
